// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the accumulator core.
// The clock and reset are taken from the scope of the macro's user,
// which must provide clk_i and an active-low rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, disabled while reset is asserted.
`define ACM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define ACM_ASSERT_IMPL(lbl, ante, cons, msg) \
  `ACM_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ACM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `ACM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/acm_pkg.sv -----
// ----------------------------------------------------------------------------
// acm_pkg
// Types, codes and constants shared by the accumulator core modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acm_pkg;

  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned MEM_DEPTH  = 256;
  localparam int unsigned ADDR_SPACE = 1 << ADDR_W;
  localparam int unsigned IDX_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef logic [IDX_W-1:0] mem_idx_t;
  typedef mem_idx_t idx_map_t [ADDR_SPACE];

  // Maps every byte address onto a memory entry, wrapping modulo the depth.
  function automatic idx_map_t build_idx_map();
    idx_map_t m;
    for (int i = 0; i < ADDR_SPACE; i++) begin
      m[i] = mem_idx_t'(i % MEM_DEPTH);
    end
    return m;
  endfunction

  localparam idx_map_t MEM_IDX_MAP = build_idx_map();

  typedef enum logic [1:0] {
    OPER_WRITE = 2'd0,
    OPER_READ  = 2'd1,
    OPER_EXEC  = 2'd2,
    OPER_NONE  = 2'd3
  } oper_e;

  typedef enum logic [7:0] {
    OPC_HLT   = 8'h00,
    OPC_LOAD  = 8'h01,
    OPC_STORE = 8'h02,
    OPC_ADD   = 8'h03,
    OPC_IN    = 8'h04,
    OPC_OUT   = 8'h05
  } opcode_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_HALT = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ADDR_W-1:0] program_counter;
    logic [DATA_W-1:0] accumulator;
    logic              out_valid;
    logic [DATA_W-1:0] out_value;
    logic              input_taken;
    logic [1:0]        run_status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/acm_ifs.sv -----
// ----------------------------------------------------------------------------
// acm_ifs
// Valid/ready channels carrying command items in and result items out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface acm_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [acm_pkg::ADDR_W-1:0] address;
  logic [acm_pkg::DATA_W-1:0] data;

  modport source (output valid, output operation, output address, output data,
                  input ready);
  modport sink   (input valid, input operation, input address, input data,
                  output ready);
endinterface

interface acm_out_if;
  logic                       valid;
  logic                       ready;
  logic [acm_pkg::DATA_W-1:0] read_data;
  logic [acm_pkg::ADDR_W-1:0] program_counter;
  logic [acm_pkg::DATA_W-1:0] accumulator;
  logic                       out_valid;
  logic [acm_pkg::DATA_W-1:0] out_value;
  logic                       input_taken;
  logic [1:0]                 run_status;

  modport source (output valid, output read_data, output program_counter,
                  output accumulator, output out_valid, output out_value,
                  output input_taken, output run_status, input ready);
  modport sink   (input valid, input read_data, input program_counter,
                  input accumulator, input out_valid, input out_value,
                  input input_taken, input run_status, output ready);
endinterface

`default_nettype wire

// ----- rtl/acm_mem.sv -----
// ----------------------------------------------------------------------------
// acm_mem
// Single-port byte memory with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acm_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  acm_pkg::mem_req_t          req_i,
  output logic [acm_pkg::DATA_W-1:0] rdata_o
);
  import acm_pkg::*;

  logic [DATA_W-1:0]    mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [DATA_W-1:0]    rdata_q;
  mem_idx_t             idx;

  assign idx = MEM_IDX_MAP[req_i.addr];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[idx] <= req_i.wdata;
    end
  end

  // An entry not written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr) begin
      vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rdata_q <= vld_q[idx] ? mem_q[idx] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/acm_ctrl.sv -----
// ----------------------------------------------------------------------------
// acm_ctrl
// Sequencer and architectural registers; one shared adder serves both the
// program counter increment and the ADD instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  acm_pkg::oper_e             oper_i,
  input  logic [acm_pkg::ADDR_W-1:0] addr_i,
  input  logic [acm_pkg::DATA_W-1:0] data_i,
  input  logic                       take_i,
  output logic                       idle_o,
  output logic                       done_o,
  output acm_pkg::mem_req_t          mem_req_o,
  input  logic [acm_pkg::DATA_W-1:0] mem_rdata_i,
  output acm_pkg::res_t              res_o
);
  import acm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RDWAIT = 6'b000010,
    S_DECODE = 6'b000100,
    S_EADDR  = 6'b001000,
    S_OPND   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] pc_q, pc_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] data_q, data_d;
  opcode_e           opc_q, opc_d;
  logic [DATA_W-1:0] rd_q, rd_d;
  logic              ovalid_q, ovalid_d;
  logic              taken_q, taken_d;

  logic [DATA_W-1:0] add_a, add_b, add_sum;

  // The adder increments the counter during fetches and adds the operand
  // once the operand byte has arrived.
  assign add_a   = (state_q == S_OPND) ? acc_q : pc_q;
  assign add_b   = (state_q == S_OPND) ? mem_rdata_i : DATA_W'(1);
  assign add_sum = add_a + add_b;

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    acc_d     = acc_q;
    status_d  = status_q;
    data_d    = data_q;
    opc_d     = opc_q;
    rd_d      = rd_q;
    ovalid_d  = ovalid_q;
    taken_d   = taken_q;
    mem_req_o = '0;
    mem_req_o.addr  = pc_q;
    mem_req_o.wdata = acc_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rd_d     = '0;
          ovalid_d = 1'b0;
          taken_d  = 1'b0;
          data_d   = data_i;
          case (oper_i)
            OPER_WRITE: begin
              mem_req_o.wr    = 1'b1;
              mem_req_o.addr  = addr_i;
              mem_req_o.wdata = data_i;
              state_d         = S_DONE;
            end
            OPER_READ: begin
              mem_req_o.rd   = 1'b1;
              mem_req_o.addr = addr_i;
              state_d        = S_RDWAIT;
            end
            OPER_EXEC: begin
              if (status_q == ST_RUN) begin
                mem_req_o.rd = 1'b1;
                pc_d         = add_sum;
                state_d      = S_DECODE;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        rd_d    = mem_rdata_i;
        state_d = S_DONE;
      end
      S_DECODE: begin
        opc_d = opcode_e'(mem_rdata_i);
        case (opcode_e'(mem_rdata_i))
          OPC_HLT: begin
            status_d = ST_HALT;
            state_d  = S_DONE;
          end
          OPC_LOAD, OPC_STORE, OPC_ADD: begin
            mem_req_o.rd = 1'b1;
            pc_d         = add_sum;
            state_d      = S_EADDR;
          end
          OPC_IN: begin
            acc_d   = data_q;
            taken_d = 1'b1;
            state_d = S_DONE;
          end
          OPC_OUT: begin
            ovalid_d = 1'b1;
            state_d  = S_DONE;
          end
          default: begin
            status_d = ST_BAD;
            state_d  = S_DONE;
          end
        endcase
      end
      S_EADDR: begin
        mem_req_o.addr = mem_rdata_i;
        if (opc_q == OPC_STORE) begin
          mem_req_o.wr = 1'b1;
          state_d      = S_DONE;
        end else begin
          mem_req_o.rd = 1'b1;
          state_d      = S_OPND;
        end
      end
      S_OPND: begin
        acc_d   = (opc_q == OPC_ADD) ? add_sum : mem_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      acc_q    <= '0;
      status_q <= ST_RUN;
      ovalid_q <= 1'b0;
      taken_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      acc_q    <= acc_d;
      status_q <= status_d;
      ovalid_q <= ovalid_d;
      taken_q  <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    opc_q  <= opc_d;
    rd_q   <= rd_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    res_o                 = '0;
    res_o.read_data       = rd_q;
    res_o.program_counter = pc_q;
    res_o.accumulator     = acc_q;
    res_o.out_valid       = ovalid_q;
    res_o.out_value       = ovalid_q ? acc_q : '0;
    res_o.input_taken     = taken_q;
    res_o.run_status      = status_q;
  end

endmodule

`default_nettype wire

// ----- rtl/accumulator_cpu_core.sv -----
// ----------------------------------------------------------------------------
// accumulator_cpu_core
// 8-bit accumulator machine with a byte memory, one command item at a time.
// ----------------------------------------------------------------------------
// Each item is taken in the idle state and walks the sequencer states to
// done, which moves its result into the output register once that is free
// or being read. A memory write, or an execute while stopped or of an
// unknown operation code, goes straight to done, a read via read wait,
// HLT, IN and OUT via decode, STORE via decode and address fetch, and
// LOAD or ADD via those and operand read, as the single memory port with
// registered read carries opcode, address byte and operand reads in turn.
// The next item is taken in the cycle after the result moves into the
// output register, even if it still waits to be taken. Memory reads as all
// zero after reset by per-byte valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_cpu_core (
  input  logic clk_i,
  input  logic rst_ni,
  acm_in_if.sink     in_i,
  acm_out_if.source  out_o
);
  import acm_pkg::*;

  logic              idle;
  logic              done;
  logic              take;
  logic              start;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  res_t              res;
  logic              out_vld_q;
  res_t              res_q;

  assign in_i.ready = idle;
  assign start      = in_i.valid & idle;
  assign take       = ~out_vld_q | out_o.ready;

  acm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .oper_i      (oper_e'(in_i.operation)),
    .addr_i      (in_i.address),
    .data_i      (in_i.data),
    .take_i      (take),
    .idle_o      (idle),
    .done_o      (done),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_o       (res)
  );

  acm_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (done && take) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && take) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.read_data       = res_q.read_data;
  assign out_o.program_counter = res_q.program_counter;
  assign out_o.accumulator     = res_q.accumulator;
  assign out_o.out_valid       = res_q.out_valid;
  assign out_o.out_value       = res_q.out_value;
  assign out_o.input_taken     = res_q.input_taken;
  assign out_o.run_status      = res_q.run_status;

endmodule

`default_nettype wire

// ----- rtl/acm_checker.sv -----
// ----------------------------------------------------------------------------
// acm_checker
// Port-level checks on the accumulator core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module acm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_flag_i,
  input logic [acm_pkg::DATA_W-1:0] out_value_i,
  input logic                       input_taken_i,
  input logic [1:0]                 run_status_i
);
  import acm_pkg::*;

  // Only one item is in flight, so ready must drop after an accept.
  `ACM_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i, "item accepted while busy")

  `ACM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // A single instruction cannot be both IN and OUT.
  `ACM_ASSERT_IMPL(a_flags_excl, out_valid_i, !(out_flag_i && input_taken_i), "IN and OUT together")

  `ACM_ASSERT_IMPL(a_value_zero, out_valid_i && !out_flag_i, out_value_i == '0, "stray out value")

  // IN and OUT only execute on a running machine and leave it running.
  `ACM_ASSERT_IMPL(a_io_running, out_valid_i && (out_flag_i || input_taken_i), run_status_i == ST_RUN, "I/O while stopped")

endmodule

bind accumulator_cpu_core acm_checker u_acm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_flag_i    (out_o.out_valid),
  .out_value_i   (out_o.out_value),
  .input_taken_i (out_o.input_taken),
  .run_status_i  (out_o.run_status)
);

`default_nettype wire
